/* hw/rtl/snp_pkg.sv */
// ----------------------------------------------------------------------------
// snp_pkg
// Shared types and constants for the sensor packet parser: request structs,
// status codes and header characters.
// ----------------------------------------------------------------------------
package snp_pkg;

  // Header characters
  localparam logic [7:0] HDR_S = 8'h73;  // 's'
  localparam logic [7:0] HDR_N = 8'h6E;  // 'n'
  localparam logic [7:0] HDR_P = 8'h70;  // 'p'

  // Checksum seed once the header has been seen: 's' + 'n' + 'p'
  localparam logic [15:0] HDR_SUM = 16'({8'd0, HDR_S} + {8'd0, HDR_N} + {8'd0, HDR_P});

  // Buffer length below which a broken buffer reports TOO_SHORT
  localparam logic [2:0] MIN_BUF_LEN = 3'd7;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [2:0] ST_NO_HEADER  = 3'd2;
  localparam logic [2:0] ST_INCOMPLETE = 3'd3;
  localparam logic [2:0] ST_BAD_CSUM   = 3'd4;

  // Result queue depth (must be a power of two, at least two)
  localparam int unsigned RQ_DEPTH = 4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } snp_in_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic [2:0] status;
    logic [7:0] register_address;
    logic [7:0] packet_type;
    logic [5:0] payload_length;
    logic       end_of_run;
  } snp_out_t;

endpackage

/* hw/rtl/snp_sensor_packet_parser.sv */
// ----------------------------------------------------------------------------
// snp_sensor_packet_parser
// Byte-serial 'snp' packet parser: finds the header in each receive buffer,
// streams the payload and reports one status per buffer.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake             payload
//   -------  ---  --------------------  -------------------------------------
//   in_      in   in_valid / in_ready   snp_in_t  (rx_byte, buffer_end)
//   out_     out  out_valid / out_ready snp_out_t (payload byte or status)
//
// One byte per cycle while in_ready is high: each accepted request updates the
// parse state in the same cycle and pushes zero, one or two results into a
// small result queue. A byte that both carries payload and ends the buffer
// yields two results. in_ready drops only when the queue has fewer than two
// free slots, so a stalled output side throttles the input after two or three
// requests that produce results.
// rst_n is synchronous, active low; it clears the parse state and the queue.
//
module snp_sensor_packet_parser #(
  parameter int unsigned RqDepth = snp_pkg::RQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  snp_pkg::snp_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output snp_pkg::snp_out_t out_data
);
  import snp_pkg::*;

  localparam int unsigned PtrW = $clog2(RqDepth);
  localparam int unsigned CntW = PtrW + 1;

  // One-hot parse phase
  typedef enum logic [6:0] {
    PH_SEARCH = 7'b0000001,
    PH_TYPE   = 7'b0000010,
    PH_ADDR   = 7'b0000100,
    PH_PAY    = 7'b0001000,
    PH_CKH    = 7'b0010000,
    PH_CKL    = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  // Parse state
  phase_t      phase_r,  phase_nxt;
  logic [15:0] prev_r,   prev_nxt;    // last two bytes, newest low
  logic [2:0]  bcnt_r,   bcnt_nxt;    // bytes in buffer, saturating
  logic [7:0]  type_r,   type_nxt;
  logic [7:0]  addr_r,   addr_nxt;
  logic [5:0]  len_r,    len_nxt;
  logic [5:0]  pcnt_r,   pcnt_nxt;
  logic [15:0] sum_r,    sum_nxt;
  logic [7:0]  ckh_r,    ckh_nxt;

  // Results from this byte
  snp_out_t    res_a, res_b;
  logic        vld_a, vld_b;

  // Result queue
  snp_out_t            rq_mem [RqDepth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     cnt_r,    cnt_nxt;

  logic        accept;
  logic        pop;
  logic [1:0]  push_n;
  logic [5:0]  pcnt_inc;
  logic [7:0]  b;

  assign b        = in_data.rx_byte;
  // Room for two results is always kept for the next byte
  assign in_ready = (cnt_r <= CntW'(RqDepth - 2));
  assign accept   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = rq_mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign pcnt_inc  = pcnt_r + 6'd1;

  // --------------------------------------------------------------------------
  // Per-byte parse step
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = {prev_r[7:0], b};
    bcnt_nxt  = (bcnt_r < MIN_BUF_LEN) ? bcnt_r + 3'd1 : bcnt_r;
    type_nxt  = type_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    pcnt_nxt  = pcnt_r;
    sum_nxt   = sum_r;
    ckh_nxt   = ckh_r;

    res_a = '0;
    res_b = '0;
    vld_a = 1'b0;
    vld_b = 1'b0;

    case (phase_r)
      PH_SEARCH: begin
        if (prev_r[15:8] == HDR_S && prev_r[7:0] == HDR_N && b == HDR_P) begin
          sum_nxt   = HDR_SUM;
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_nxt = b;
        // bit 7 has-data, bit 6 batch, bits 5..2 batch count
        if (!b[7])      len_nxt = 6'd0;
        else if (b[6])  len_nxt = {b[5:2], 2'b00};
        else            len_nxt = 6'd4;
        sum_nxt   = sum_r + {8'd0, b};
        phase_nxt = PH_ADDR;
      end
      PH_ADDR: begin
        addr_nxt  = b;
        sum_nxt   = sum_r + {8'd0, b};
        pcnt_nxt  = 6'd0;
        phase_nxt = (len_r != 6'd0) ? PH_PAY : PH_CKH;
      end
      PH_PAY: begin
        vld_a                  = 1'b1;
        res_a.is_status        = 1'b0;
        res_a.payload_byte     = b;
        res_a.payload_index    = pcnt_r;
        res_a.status           = ST_OK;
        res_a.register_address = addr_r;
        res_a.packet_type      = type_r;
        res_a.payload_length   = len_r;
        sum_nxt  = sum_r + {8'd0, b};
        pcnt_nxt = pcnt_inc;
        if (pcnt_inc >= len_r) phase_nxt = PH_CKH;
      end
      PH_CKH: begin
        ckh_nxt   = b;
        phase_nxt = PH_CKL;
      end
      PH_CKL: begin
        vld_a                  = 1'b1;
        res_a.is_status        = 1'b1;
        res_a.status           = ({ckh_r, b} == sum_r) ? ST_OK : ST_BAD_CSUM;
        res_a.register_address = addr_r;
        res_a.packet_type      = type_r;
        res_a.payload_length   = len_r;
        phase_nxt = PH_DONE;
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // Buffer end: report a buffer with no finished packet, then drop all buffer state
    if (in_data.buffer_end) begin
      if (phase_nxt != PH_DONE) begin
        vld_b                  = 1'b1;
        res_b.is_status        = 1'b1;
        if (bcnt_nxt < MIN_BUF_LEN)    res_b.status = ST_TOO_SHORT;
        else if (phase_nxt == PH_SEARCH) res_b.status = ST_NO_HEADER;
        else                             res_b.status = ST_INCOMPLETE;
        res_b.register_address = addr_nxt;
        res_b.packet_type      = type_nxt;
        res_b.payload_length   = len_nxt;
      end
      phase_nxt = PH_SEARCH;
      prev_nxt  = '0;
      bcnt_nxt  = '0;
      type_nxt  = '0;
      addr_nxt  = '0;
      len_nxt   = '0;
      pcnt_nxt  = '0;
      sum_nxt   = '0;
      ckh_nxt   = '0;
    end

    res_a.end_of_run = !vld_b;
    res_b.end_of_run = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Result queue bookkeeping
  // --------------------------------------------------------------------------
  always_comb begin
    push_n = '0;
    if (accept) push_n = {1'b0, vld_a} + {1'b0, vld_b};
    wr_ptr_nxt = wr_ptr_r + PtrW'(push_n);
    rd_ptr_nxt = pop ? rd_ptr_r + PtrW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      prev_r   <= '0;
      bcnt_r   <= '0;
      type_r   <= '0;
      addr_r   <= '0;
      len_r    <= '0;
      pcnt_r   <= '0;
      sum_r    <= '0;
      ckh_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        prev_r  <= prev_nxt;
        bcnt_r  <= bcnt_nxt;
        type_r  <= type_nxt;
        addr_r  <= addr_nxt;
        len_r   <= len_nxt;
        pcnt_r  <= pcnt_nxt;
        sum_r   <= sum_nxt;
        ckh_r   <= ckh_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage: first result at the write pointer, second right after it
  always_ff @(posedge clk) begin
    if (accept) begin
      if (vld_a) begin
        rq_mem[wr_ptr_r] <= res_a;
        if (vld_b) rq_mem[wr_ptr_r + PtrW'(1)] <= res_b;
      end else if (vld_b) begin
        rq_mem[wr_ptr_r] <= res_b;
      end
    end
  end

endmodule

/* hw/rtl/snp_chk.sv */
// ----------------------------------------------------------------------------
// snp_chk
// Port-level checks for the sensor packet parser, bound to the top level.
// ----------------------------------------------------------------------------
module snp_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input snp_pkg::snp_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input snp_pkg::snp_out_t out_data
);
  import snp_pkg::*;

  // A waiting input request holds with the same payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input request changed before acceptance");

  // A pending result request stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before acceptance");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // A status always closes the run of results for its byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_status |-> out_data.end_of_run)
    else $error("status result not marked end_of_run");

  // Payload bytes lie inside the decoded payload and carry no status
  a_pay_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_status |->
      (out_data.payload_index < out_data.payload_length) &&
      (out_data.status == ST_OK))
    else $error("payload result out of range");

endmodule

bind snp_sensor_packet_parser snp_chk u_snp_chk (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the snp packet parser: receive buffers of good,
// corrupted, truncated and header-less packets go in one request at a time;
// every result is checked against a cycle-free model of the parse.
// ----------------------------------------------------------------------------
module tb_top;
  import snp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Parse position inside one receive buffer
  typedef enum logic [2:0] {
    SEEK_HDR,
    TAKE_TYPE,
    TAKE_ADDR,
    TAKE_PAYLOAD,
    TAKE_SUM_HI,
    TAKE_SUM_LO,
    PKT_DONE
  } parse_phase_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  snp_in_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  snp_out_t  out_data;

  snp_sensor_packet_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Requests waiting to be driven, and results the parser still owes us
  snp_in_t  pending_reqs[$];
  snp_out_t expected_results[$];

  int unsigned cycle_count = 0;
  int unsigned err_count = 0;
  logic        in_taken = 1'b0;

  // Shadow of the parser state for the buffer in progress
  parse_phase_t parse_phase = SEEK_HDR;
  logic [15:0]  last_two = '0;
  logic [2:0]   buf_len = '0;
  logic [7:0]   pkt_type = '0;
  logic [7:0]   pkt_addr = '0;
  logic [5:0]   pkt_len = '0;
  logic [5:0]   pay_count = '0;
  logic [15:0]  csum_acc = '0;
  logic [7:0]   ck_high = '0;

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Parse model
  // ---------------------------------------------------------------------------

  // Payload size from the type byte: no data -> 0, single -> 4, batch -> 4*count
  function automatic logic [5:0] payload_len_of(input logic [7:0] ptype);
    if (!ptype[7]) return 6'd0;
    if (ptype[6]) return {ptype[5:2], 2'b00};
    return 6'd4;
  endfunction

  // Result carrying the held packet fields of the current buffer
  function automatic snp_out_t held_result(input logic is_st, input logic [7:0] pbyte,
                                           input logic [5:0] pidx, input logic [2:0] st);
    snp_out_t r;
    r = '0;
    r.is_status        = is_st;
    r.payload_byte     = pbyte;
    r.payload_index    = pidx;
    r.status           = st;
    r.register_address = pkt_addr;
    r.packet_type      = pkt_type;
    r.payload_length   = pkt_len;
    r.end_of_run       = 1'b0;
    return r;
  endfunction

  task automatic clear_parse();
    parse_phase = SEEK_HDR;
    last_two    = '0;
    buf_len     = '0;
    pkt_type    = '0;
    pkt_addr    = '0;
    pkt_len     = '0;
    pay_count   = '0;
    csum_acc    = '0;
    ck_high     = '0;
  endtask

  // Advance the model by one accepted byte and queue the results it causes
  task automatic predict_byte(input snp_in_t req);
    snp_out_t    emitted[2];
    int unsigned n_emit;
    logic [7:0]  b;
    logic [2:0]  st;
    n_emit = 0;
    b = req.rx_byte;
    if (buf_len < MIN_BUF_LEN) buf_len = buf_len + 3'd1;

    case (parse_phase)
      SEEK_HDR: begin
        if (last_two == {HDR_S, HDR_N} && b == HDR_P) begin
          csum_acc    = HDR_SUM;
          parse_phase = TAKE_TYPE;
        end
      end
      TAKE_TYPE: begin
        pkt_type    = b;
        pkt_len     = payload_len_of(b);
        csum_acc    = csum_acc + 16'(b);
        parse_phase = TAKE_ADDR;
      end
      TAKE_ADDR: begin
        pkt_addr    = b;
        csum_acc    = csum_acc + 16'(b);
        pay_count   = '0;
        parse_phase = (pkt_len != 0) ? TAKE_PAYLOAD : TAKE_SUM_HI;
      end
      TAKE_PAYLOAD: begin
        emitted[n_emit] = held_result(1'b0, b, pay_count, ST_OK);
        n_emit++;
        csum_acc  = csum_acc + 16'(b);
        pay_count = pay_count + 6'd1;
        if (pay_count >= pkt_len) parse_phase = TAKE_SUM_HI;
      end
      TAKE_SUM_HI: begin
        ck_high     = b;
        parse_phase = TAKE_SUM_LO;
      end
      TAKE_SUM_LO: begin
        st = ({ck_high, b} == csum_acc) ? ST_OK : ST_BAD_CSUM;
        emitted[n_emit] = held_result(1'b1, 8'd0, 6'd0, st);
        n_emit++;
        parse_phase = PKT_DONE;
      end
      default: parse_phase = PKT_DONE;
    endcase

    last_two = {last_two[7:0], b};

    // Buffer closed with no finished packet: one status for the buffer
    if (req.buffer_end) begin
      if (parse_phase != PKT_DONE) begin
        if (buf_len < MIN_BUF_LEN) st = ST_TOO_SHORT;
        else if (parse_phase == SEEK_HDR) st = ST_NO_HEADER;
        else st = ST_INCOMPLETE;
        emitted[n_emit] = held_result(1'b1, 8'd0, 6'd0, st);
        n_emit++;
      end
      clear_parse();
    end

    if (n_emit > 0) emitted[n_emit-1].end_of_run = 1'b1;
    for (int i = 0; i < n_emit; i++) expected_results.push_back(emitted[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_result(input snp_out_t got);
    snp_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: %h", got));
      return;
    end
    want = expected_results.pop_front();
    if (got.is_status !== want.is_status)
      report_mismatch($sformatf("is_status %b, want %b", got.is_status, want.is_status));
    if (got.payload_byte !== want.payload_byte)
      report_mismatch($sformatf("payload_byte %h, want %h",
                                got.payload_byte, want.payload_byte));
    if (got.payload_index !== want.payload_index)
      report_mismatch($sformatf("payload_index %0d, want %0d",
                                got.payload_index, want.payload_index));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.register_address !== want.register_address)
      report_mismatch($sformatf("register_address %h, want %h",
                                got.register_address, want.register_address));
    if (got.packet_type !== want.packet_type)
      report_mismatch($sformatf("packet_type %h, want %h",
                                got.packet_type, want.packet_type));
    if (got.payload_length !== want.payload_length)
      report_mismatch($sformatf("payload_length %0d, want %0d",
                                got.payload_length, want.payload_length));
    if (got.end_of_run !== want.end_of_run)
      report_mismatch($sformatf("end_of_run %b, want %b", got.end_of_run, want.end_of_run));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic [7:0] b, input logic last);
    snp_in_t r;
    r.rx_byte    = b;
    r.buffer_end = last;
    pending_reqs.push_back(r);
  endtask

  // Filler biased toward header characters so false and split headers show up
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0: return HDR_S;
      1: return HDR_N;
      2: return HDR_P;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_noise(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_req(noise_byte(), i == len - 1);
  endtask

  // One buffer holding a packet: lead-in filler, header, type, address,
  // payload, checksum and trailing bytes. A nonzero cut truncates the buffer.
  task automatic queue_packet(input logic [7:0] ptype, input logic [7:0] addr,
                              input int unsigned lead, input bit corrupt,
                              input int unsigned cut, input int unsigned tail);
    logic [7:0]  bytes[$];
    logic [7:0]  b;
    logic [15:0] sum;
    logic [5:0]  plen;
    for (int unsigned i = 0; i < lead; i++) bytes.push_back(noise_byte());
    bytes.push_back(HDR_S);
    bytes.push_back(HDR_N);
    bytes.push_back(HDR_P);
    bytes.push_back(ptype);
    bytes.push_back(addr);
    sum  = HDR_SUM + 16'(ptype) + 16'(addr);
    plen = payload_len_of(ptype);
    for (int unsigned i = 0; i < plen; i++) begin
      b = 8'($urandom);
      bytes.push_back(b);
      sum = sum + 16'(b);
    end
    if (corrupt) sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
    bytes.push_back(sum[15:8]);
    bytes.push_back(sum[7:0]);
    for (int unsigned i = 0; i < tail; i++) bytes.push_back(noise_byte());
    if (cut > 0)
      while (bytes.size() > cut) void'(bytes.pop_back());
    for (int i = 0; i < bytes.size(); i++) push_req(bytes[i], i == bytes.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]  no_hdr[7];
    logic [7:0]  ptype;
    int unsigned kind;
    int unsigned target;
    int unsigned full_len;
    int unsigned lead;

    no_hdr = '{8'h00, 8'hFF, HDR_S, HDR_N, 8'h00, HDR_N, HDR_P};

    // Directed: header in a buffer too short to hold a packet
    queue_packet(8'h80, 8'h12, 0, 1'b0, 4, 0);
    // Zero-length packet despite batch bits (no has-data), top address,
    // trailing byte after the checksum must be ignored
    queue_packet(8'h7F, 8'hFF, 0, 1'b0, 0, 1);
    // Largest batch, buffer cut on a payload byte: payload plus incomplete
    queue_packet(8'hFF, 8'h00, 0, 1'b0, 8, 0);
    // Header characters out of order: no header
    foreach (no_hdr[i]) push_req(no_hdr[i], i == 6);

    // Random: mostly well-formed packets, some truncated, some pure noise
    target = pending_reqs.size() + RANDOM_ITEMS;
    while (pending_reqs.size() < target) begin
      kind  = $urandom_range(0, 99);
      ptype = 8'($urandom);
      if ($urandom_range(0, 9) != 0) ptype[7] = 1'b1;
      // keep most batches short; the longest ones stay rare
      if ($urandom_range(0, 9) < 8) ptype[5:2] = 4'($urandom_range(0, 3));
      lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      full_len = lead + 7 + payload_len_of(ptype);
      if (kind < 70)
        queue_packet(ptype, 8'($urandom), lead, $urandom_range(0, 99) < 15, 0,
                     $urandom_range(0, 3));
      else if (kind < 85)
        queue_packet(ptype, 8'($urandom), lead, 1'b0, $urandom_range(1, full_len), 0);
      else
        queue_noise($urandom_range(1, 12));
    end

    // Drain: everything sent, every result back, then a quiet window
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: requests and output backpressure change on the falling edge.
  // A window of cycles runs with no idling on either side.
  // ---------------------------------------------------------------------------
  function automatic bit take_break();
    if (cycle_count >= 800 && cycle_count < 1400) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      // valid holds with the same payload until the request is taken
      if (!in_valid || in_taken) begin
        if (pending_reqs.size() != 0 && !take_break()) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !take_break();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge. The model runs
  // before the check so a same-edge result can never race its expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) predict_byte(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end else begin
      in_taken <= 1'b0;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
